[hw/rtl/sacl_pkg.sv]
// Shared widths, register indexes and port layout of the cache tag directory.
package sacl_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_LINE_OFFSET_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SET_INDEX_WIDTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WAYS_LOG2         = 2'd2;

    localparam int OFFSET_CFG_W = 4;
    localparam int SET_CFG_W    = 3;
    localparam int WAYS_CFG_W   = 2;

    localparam logic [OFFSET_CFG_W-1:0] OFFSET_W_RESET = 4'd4;
    localparam logic [SET_CFG_W-1:0]    SET_W_RESET    = 3'd6;
    localparam logic [WAYS_CFG_W-1:0]   WAYS_LOG2_RESET = 2'd0;

    // widest byte offset the block splits off
    localparam logic [OFFSET_CFG_W-1:0] OFFSET_W_MAX = 4'd8;

    // result fields
    localparam int HIT_FLAG_W    = 1;
    localparam int WAY_USED_W    = 3;
    localparam int TAG_VALUE_W   = 16;
    localparam int SET_NUMBER_W  = 6;
    localparam int BYTE_OFFSET_W = 8;
    localparam int TOTAL_W       = 32;

    localparam int S_TDATA_W = 16;
    localparam int M_FIELDS_W = HIT_FLAG_W + WAY_USED_W + TAG_VALUE_W + SET_NUMBER_W
                              + BYTE_OFFSET_W + 2 * TOTAL_W;
    localparam int M_TDATA_W = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELDS_W;

endpackage

[hw/rtl/sacl_set_mem.sv]
// Set memory: one row per set, one write port and one registered read port.
module sacl_set_mem #(
    parameter int DEPTH   = 64,
    parameter int ADDR_W  = 6,
    parameter int DATA_W  = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-during-write to the same row returns the old row
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/sacl_way_update.sv]
// Tag compare, victim choice and LRU rank update for one set row.
module sacl_way_update #(
    parameter int ADDR_WIDTH = 16,
    parameter int MAX_WAYS   = 8,
    parameter int RANK_W     = 3,
    parameter int WAY_W      = 3,
    parameter int ROW_W      = MAX_WAYS * (1 + ADDR_WIDTH + RANK_W)
) (
    input  logic [ROW_W-1:0]                   row_in,
    input  logic [ADDR_WIDTH-1:0]              tag,
    input  logic [sacl_pkg::WAYS_CFG_W-1:0]    ways_log2,
    output logic [ROW_W-1:0]                   row_out,
    output logic                               hit,
    output logic [WAY_W-1:0]                   way
);

    typedef struct packed {
        logic                  valid;
        logic [ADDR_WIDTH-1:0] tag;
        logic [RANK_W-1:0]     rank;
    } way_entry_t;

    localparam int NWAYS_W = (1 << sacl_pkg::WAYS_CFG_W) + 1;

    way_entry_t [MAX_WAYS-1:0] row;
    way_entry_t [MAX_WAYS-1:0] row_new;
    logic [MAX_WAYS-1:0]       active;
    logic [MAX_WAYS-1:0]       match;
    logic [MAX_WAYS-1:0]       empty;
    logic [NWAYS_W-1:0]        nways;
    logic [WAY_W-1:0]          hit_way;
    logic [WAY_W-1:0]          empty_way;
    logic [WAY_W-1:0]          lru_way;
    logic [RANK_W-1:0]         best_rank;
    logic [WAY_W-1:0]          sel_way;
    logic [RANK_W-1:0]         old_rank;

    assign row   = row_in;
    assign nways = NWAYS_W'(1) << ways_log2;

    always_comb begin
        for (int v = 0; v < MAX_WAYS; v++) begin
            active[v] = v < int'(nways);
            match[v]  = active[v] && row[v].valid && (row[v].tag == tag);
            empty[v]  = active[v] && !row[v].valid;
        end
    end

    // lowest-numbered matching and lowest-numbered empty way
    always_comb begin
        hit_way   = '0;
        empty_way = '0;
        for (int v = MAX_WAYS - 1; v >= 0; v--) begin
            if (match[v]) begin
                hit_way = WAY_W'(v);
            end
            if (empty[v]) begin
                empty_way = WAY_W'(v);
            end
        end
    end

    // oldest way, lowest number on a tie
    always_comb begin
        best_rank = '0;
        lru_way   = '0;
        for (int v = 0; v < MAX_WAYS; v++) begin
            if (active[v] && row[v].rank > best_rank) begin
                best_rank = row[v].rank;
                lru_way   = WAY_W'(v);
            end
        end
    end

    assign hit = |match;

    always_comb begin
        priority if (hit) begin
            sel_way = hit_way;
        end else if (|empty) begin
            sel_way = empty_way;
        end else begin
            sel_way = lru_way;
        end
    end

    assign old_rank = row[sel_way].valid ? row[sel_way].rank : RANK_W'(MAX_WAYS - 1);

    always_comb begin
        row_new = row;
        for (int v = 0; v < MAX_WAYS; v++) begin
            if (active[v] && (WAY_W'(v) != sel_way) && row[v].valid
                    && (row[v].rank < old_rank)) begin
                row_new[v].rank = RANK_W'(row[v].rank + 1'b1);
            end
        end
        row_new[sel_way].rank = '0;
        if (!hit) begin
            row_new[sel_way].valid = 1'b1;
            row_new[sel_way].tag   = tag;
        end
    end

    assign row_out = row_new;
    assign way     = sel_way;

endmodule

[hw/rtl/set_assoc_cache_lru_lookup.sv]
// Tag directory of a set-associative cache with exact LRU replacement.
//
// Input channel s_*: one byte address per transfer. The address is split into
// byte offset, set and tag under the configured widths; the set row is read
// from the set memory, compared, updated and written back.
// Result channel m_*: one transfer per address with hit flag, way, address
// parts and saturating hit and miss totals.
// An accepted address passes the lookup stage and then the result register, which drives m_tvalid.
// Throughput: one address per cycle while m_tready stays high; the single read
// and write port of the set memory sets that figure. A row written back while the
// next address reads the same set is forwarded from a holding register.
// Reset: configuration returns to offset 4, set width 6, direct mapped, and
// the totals clear. A clearing pass then writes every set row to zero, one
// row a cycle; s_tready stays low until it ends.
// Stall: the result register holds while m_tready is low; the lookup stage
// holds behind it and, outside the clearing pass, s_tready drops only when both are full.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0 offset
// width, 1 set width, 2 ways log2); other indexes are ignored.
module set_assoc_cache_lru_lookup #(
    parameter int ADDR_WIDTH = 16,
    parameter int MAX_SETS   = 64,
    parameter int MAX_WAYS   = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sacl_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] access_addr

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] hit_flag, [3:1] way_used, [19:4] tag_value, [25:20] set_number,
    // [33:26] byte_offset, [65:34] hit_total, [97:66] miss_total, rest zero
    output logic [sacl_pkg::M_TDATA_W-1:0]     m_tdata,

    input  logic                               cfg_wr_en,
    input  logic [sacl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int SMAX   = $clog2(MAX_SETS + 1) - 1;
    localparam int WMAX   = $clog2(MAX_WAYS + 1) - 1;
    localparam int ROW_W  = MAX_WAYS * (1 + ADDR_WIDTH + RANK_W);
    localparam int SH_W   = sacl_pkg::OFFSET_CFG_W;

    // configuration
    logic [sacl_pkg::OFFSET_CFG_W-1:0] off_w_reg;
    logic [sacl_pkg::SET_CFG_W-1:0]    set_w_reg;
    logic [sacl_pkg::WAYS_CFG_W-1:0]   ways_reg;
    logic [sacl_pkg::OFFSET_CFG_W-1:0] off_w;
    logic [sacl_pkg::SET_CFG_W-1:0]    set_w;
    logic [sacl_pkg::WAYS_CFG_W-1:0]   ways_l2;

    // clearing pass
    logic                 clearing_reg;
    logic [SET_W-1:0]     clr_idx_reg;

    // address split
    logic [ADDR_WIDTH+sacl_pkg::S_TDATA_W-1:0] addr_ext;
    logic [ADDR_WIDTH-1:0]                     addr;
    logic [ADDR_WIDTH+SET_W-1:0]               set_shift;
    logic [SH_W-1:0]                           tag_sh;
    logic [SET_W-1:0]                          in_set;
    logic [ADDR_WIDTH-1:0]                     in_tag;
    logic [sacl_pkg::BYTE_OFFSET_W-1:0]        in_off;

    // lookup stage
    logic                                 st1_valid_reg;
    logic                                 st1_fwd_reg;
    logic [SET_W-1:0]                     st1_set_reg;
    logic [ADDR_WIDTH-1:0]                st1_tag_reg;
    logic [sacl_pkg::BYTE_OFFSET_W-1:0]   st1_off_reg;
    logic [ROW_W-1:0]                     fwd_row_reg;
    logic                                 st1_go;
    logic                                 s_accept;
    logic                                 fwd_next;

    logic [ROW_W-1:0]     mem_rdata;
    logic [ROW_W-1:0]     row_cur;
    logic [ROW_W-1:0]     row_upd;
    logic                 look_hit;
    logic [WAY_W-1:0]     look_way;

    logic                 mem_we;
    logic [SET_W-1:0]     mem_waddr;
    logic [ROW_W-1:0]     mem_wdata;

    // totals and result register
    logic [sacl_pkg::TOTAL_W-1:0]    hit_cnt_reg;
    logic [sacl_pkg::TOTAL_W-1:0]    miss_cnt_reg;
    logic [sacl_pkg::TOTAL_W-1:0]    hit_cnt_next;
    logic [sacl_pkg::TOTAL_W-1:0]    miss_cnt_next;
    logic                            out_valid_reg;
    logic [sacl_pkg::M_TDATA_W-1:0]  out_data_reg;
    logic [sacl_pkg::M_TDATA_W-1:0]  out_data_next;

    logic [WAY_W+sacl_pkg::WAY_USED_W-1:0]        way_ext;
    logic [ADDR_WIDTH+sacl_pkg::TAG_VALUE_W-1:0]  tag_ext;
    logic [SET_W+sacl_pkg::SET_NUMBER_W-1:0]      set_ext;

    // clamp configuration to what the directory holds
    assign off_w   = (off_w_reg > sacl_pkg::OFFSET_W_MAX) ? sacl_pkg::OFFSET_W_MAX : off_w_reg;
    assign set_w   = (int'(set_w_reg) > SMAX) ? sacl_pkg::SET_CFG_W'(SMAX) : set_w_reg;
    assign ways_l2 = (int'(ways_reg) > WMAX) ? sacl_pkg::WAYS_CFG_W'(WMAX) : ways_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_w_reg <= sacl_pkg::OFFSET_W_RESET;
            set_w_reg <= sacl_pkg::SET_W_RESET;
            ways_reg  <= sacl_pkg::WAYS_LOG2_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sacl_pkg::REG_LINE_OFFSET_WIDTH: off_w_reg <= cfg_wdata;
                sacl_pkg::REG_SET_INDEX_WIDTH:
                    set_w_reg <= cfg_wdata[sacl_pkg::SET_CFG_W-1:0];
                sacl_pkg::REG_WAYS_LOG2:
                    ways_reg  <= cfg_wdata[sacl_pkg::WAYS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // split the incoming address
    assign addr_ext  = {{ADDR_WIDTH{1'b0}}, s_tdata};
    assign addr      = addr_ext[ADDR_WIDTH-1:0];
    assign set_shift = {{SET_W{1'b0}}, addr} >> off_w;
    assign in_set    = set_shift[SET_W-1:0] & ~({SET_W{1'b1}} << set_w);
    assign tag_sh    = off_w + SH_W'(set_w);
    assign in_tag    = addr >> tag_sh;
    assign in_off    = addr[sacl_pkg::BYTE_OFFSET_W-1:0]
                     & ~({sacl_pkg::BYTE_OFFSET_W{1'b1}} << off_w);

    // handshake
    assign st1_go   = st1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clearing_reg && (!st1_valid_reg || st1_go);
    assign s_accept = s_tvalid && s_tready;
    // the row being written back this cycle is not yet visible to the read
    assign fwd_next = st1_go && (st1_set_reg == in_set);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clearing_reg) begin
            if (int'(clr_idx_reg) == MAX_SETS - 1) begin
                clearing_reg <= 1'b0;
            end else begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_go) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_set_reg <= in_set;
            st1_tag_reg <= in_tag;
            st1_off_reg <= in_off;
            st1_fwd_reg <= fwd_next;
        end
        if (st1_go) begin
            fwd_row_reg <= row_upd;
        end
    end

    sacl_set_mem #(
        .DEPTH  (MAX_SETS),
        .ADDR_W (SET_W),
        .DATA_W (ROW_W)
    ) u_set_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (s_accept),
        .rd_addr (in_set),
        .rd_data (mem_rdata)
    );

    assign row_cur = st1_fwd_reg ? fwd_row_reg : mem_rdata;

    sacl_way_update #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .MAX_WAYS   (MAX_WAYS),
        .RANK_W     (RANK_W),
        .WAY_W      (WAY_W),
        .ROW_W      (ROW_W)
    ) u_way_update (
        .row_in    (row_cur),
        .tag       (st1_tag_reg),
        .ways_log2 (ways_l2),
        .row_out   (row_upd),
        .hit       (look_hit),
        .way       (look_way)
    );

    // write back the updated row, or zero a row during the clearing pass
    assign mem_we    = clearing_reg || st1_go;
    assign mem_waddr = clearing_reg ? clr_idx_reg : st1_set_reg;
    assign mem_wdata = clearing_reg ? '0 : row_upd;

    always_comb begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (look_hit) begin
            if (hit_cnt_reg != '1) begin
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end
        end else begin
            if (miss_cnt_reg != '1) begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
        end
    end

    assign way_ext = {{sacl_pkg::WAY_USED_W{1'b0}}, look_way};
    assign tag_ext = {{sacl_pkg::TAG_VALUE_W{1'b0}}, st1_tag_reg};
    assign set_ext = {{sacl_pkg::SET_NUMBER_W{1'b0}}, st1_set_reg};

    assign out_data_next = {
        {sacl_pkg::M_PAD_W{1'b0}},
        miss_cnt_next,
        hit_cnt_next,
        st1_off_reg,
        set_ext[sacl_pkg::SET_NUMBER_W-1:0],
        tag_ext[sacl_pkg::TAG_VALUE_W-1:0],
        way_ext[sacl_pkg::WAY_USED_W-1:0],
        look_hit
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (st1_go) begin
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_go) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
